// File: rtl/qse_pkg.sv
`timescale 1ns / 1ps

package qse_pkg;

   localparam int MAX_RUN   = 6;
   localparam int RUN_LEN_W = 3;
   localparam int BODY_MAX  = 4;

   localparam logic [7:0] QUOTE_CHAR  = 8'h27;
   localparam logic [7:0] BSLASH_CHAR = 8'h5C;
   localparam logic [7:0] DIGIT0_CHAR = 8'h30;
   localparam logic [7:0] PRINT_LO    = 8'd32;
   localparam logic [7:0] PRINT_HI    = 8'd126;
   localparam logic [7:0] HIGH_LO     = 8'd160;

   typedef struct packed {
      logic [7:0] ch;
      logic       first;
      logic       final_req;
      logic       no_char;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
   } rsp_type;

   // one request after classification: the bytes it expands to, oldest in slot 0
   typedef struct packed {
      logic [MAX_RUN-1:0][7:0] bytes;
      logic [RUN_LEN_W-1:0]    len;
   } run_type;

endpackage

// File: rtl/qse_front.sv
`timescale 1ns / 1ps

module qse_front (
   input  logic                req_push,
   input  qse_pkg::req_type    req_data,
   output logic                req_full,
   input  logic                q_full,
   output logic                q_push,
   output qse_pkg::run_type    q_wdata
);

   logic [qse_pkg::BODY_MAX-1:0][7:0] body;
   logic [qse_pkg::RUN_LEN_W-1:0]     blen;
   logic [qse_pkg::RUN_LEN_W-1:0]     off;
   logic [qse_pkg::RUN_LEN_W-1:0]     rel;
   logic [7:0]                        letter;
   logic                              printable;

   always_comb begin
      body   = '0;
      blen   = '0;
      letter = '0;
      rel    = '0;
      case (req_data.ch)
         8'd7:    letter = "a";
         8'd8:    letter = "b";
         8'd9:    letter = "t";
         8'd10:   letter = "n";
         8'd11:   letter = "v";
         8'd12:   letter = "f";
         8'd13:   letter = "r";
         default: letter = '0;
      endcase
      printable = (req_data.ch >= qse_pkg::PRINT_LO && req_data.ch <= qse_pkg::PRINT_HI)
                  || req_data.ch >= qse_pkg::HIGH_LO;

      if (req_data.ch == qse_pkg::QUOTE_CHAR || req_data.ch == qse_pkg::BSLASH_CHAR) begin
         body[0] = qse_pkg::BSLASH_CHAR;
         body[1] = req_data.ch;
         blen    = 3'd2;
      end else if (printable) begin
         body[0] = req_data.ch;
         blen    = 3'd1;
      end else if (letter != '0) begin
         body[0] = qse_pkg::BSLASH_CHAR;
         body[1] = letter;
         blen    = 3'd2;
      end else begin
         body[0] = qse_pkg::BSLASH_CHAR;
         body[1] = qse_pkg::DIGIT0_CHAR + {5'b0, 1'b0, req_data.ch[7:6]};
         body[2] = qse_pkg::DIGIT0_CHAR + {5'b0, req_data.ch[5:3]};
         body[3] = qse_pkg::DIGIT0_CHAR + {5'b0, req_data.ch[2:0]};
         blen    = 3'd4;
      end
      if (req_data.no_char) begin
         blen = '0;
      end

      off         = {2'b0, req_data.first};
      q_wdata.len = off + blen + {2'b0, req_data.final_req};

      // opening quote, then the body, then anything past it is the closing quote
      for (int i = 0; i < qse_pkg::MAX_RUN; i++) begin
         rel = qse_pkg::RUN_LEN_W'(i) - off;
         if (req_data.first && i == 0) begin
            q_wdata.bytes[i] = qse_pkg::QUOTE_CHAR;
         end else if (rel < blen) begin
            q_wdata.bytes[i] = body[rel[1:0]];
         end else begin
            q_wdata.bytes[i] = qse_pkg::QUOTE_CHAR;
         end
      end
   end

   assign req_full = q_full;
   // a request with nothing to emit is taken and dropped here
   assign q_push   = req_push && !q_full && (q_wdata.len != '0);

endmodule

// File: rtl/qse_queue.sv
`timescale 1ns / 1ps

module qse_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_push,
   input  qse_pkg::run_type q_wdata,
   output logic             q_full,
   input  logic             q_pop,
   output logic             q_valid,
   output qse_pkg::run_type q_rdata
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   qse_pkg::run_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign q_full  = (count_ff == CNT_W'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_rdata = slot_ff[rd_ptr_ff];
   assign do_push = q_push && !q_full;
   assign do_pop  = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= q_wdata;
      end
   end

endmodule

// File: rtl/qse_back.sv
`timescale 1ns / 1ps

module qse_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  qse_pkg::run_type  q_rdata,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output qse_pkg::rsp_type  rsp_data
);

   logic [qse_pkg::RUN_LEN_W-1:0] idx_ff, idx_in;
   logic                          out_valid_ff, out_valid_in;
   qse_pkg::rsp_type              out_ff, out_in;
   logic                          adv;
   logic                          last;

   assign adv  = q_valid && (!out_valid_ff || rsp_pop);
   assign last = (idx_ff == q_rdata.len - 1'b1);
   assign q_pop = adv && last;

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      if (adv) begin
         out_valid_in    = 1'b1;
         out_in.out_byte = q_rdata.bytes[idx_ff];
         out_in.run_end  = last;
         idx_in          = last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   // mid-run the head entry must stay put
   a_idx_in_run: assert property (@(posedge clock) disable iff (reset)
      q_valid |-> idx_ff < q_rdata.len)
      else $error("byte index past end of run");
   a_mid_run_held: assert property (@(posedge clock) disable iff (reset)
      idx_ff != '0 |-> q_valid)
      else $error("run lost from queue while partly emitted");
   a_run_end_wraps: assert property (@(posedge clock) disable iff (reset)
      adv && last |=> idx_ff == '0 && out_ff.run_end)
      else $error("run end not marked or index not rewound");

endmodule

// File: rtl/quoted_string_escaper.sv
`timescale 1ns / 1ps

// The first byte of a request passes the run queue and then the output register to rsp_data.
// Throughput: one byte per cycle from the back end while rsp_pop keeps pace; a request
// of N bytes (1 to 6) holds the back end for N bytes; plain characters go one per cycle.
// The run queue of QUEUE_DEPTH entries lets requests arrive while escapes are emitted.
// Reset (synchronous, active high) empties the run queue and the output register.
module quoted_string_escaper #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  qse_pkg::req_type req_data,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output qse_pkg::rsp_type rsp_data
);

   logic             q_full;
   logic             q_push;
   logic             q_pop;
   logic             q_valid;
   qse_pkg::run_type q_wdata;
   qse_pkg::run_type q_rdata;

   qse_front u_front (
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_wdata  (q_wdata)
   );

   qse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_wdata (q_wdata),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_valid (q_valid),
      .q_rdata (q_rdata)
   );

   qse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_rdata   (q_rdata),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
